[src/fit_policy_block_allocator_unit_assert.svh]
// Assertion macros for the fit-policy block allocator.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fpba assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FPBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fpba assertion failed");

`endif

[src/fpba_pkg.sv]
// Shared types and constants of the fit-policy block allocator.
`timescale 1ns / 1ps
`default_nettype none
package fpba_pkg;

	localparam int unsigned NUM_BLOCKS_DEF = 16;
	localparam int unsigned QUEUE_DEPTH    = 2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	localparam logic [1:0] ST_LOADED = 2'd0;
	localparam logic [1:0] ST_PLACED = 2'd1;
	localparam logic [1:0] ST_NOFIT  = 2'd2;

	typedef enum logic [1:0] {
		POL_FIRST = 2'd0,
		POL_BEST  = 2'd1,
		POL_WORST = 2'd2,
		POL_NEXT  = 2'd3
	} policy_t;

	typedef enum logic [1:0] {
		OP_LOAD      = 2'd0,
		OP_LOAD_DROP = 2'd1,
		OP_ALLOC     = 2'd2
	} op_kind_t;

	typedef struct packed {
		logic        command;
		logic [3:0]  block_index;
		logic [15:0] amount;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  block_number;
		logic [15:0] remaining;
	} out_item_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [3:0]  index;
		logic [15:0] amount;
		policy_t     policy;
	} op_t;

endpackage
`default_nettype wire

[src/fpba_front.sv]
// Front end: accepts requests, holds the policy register and classifies each request.
`timescale 1ns / 1ps
`default_nettype none
module fpba_front #(
	parameter int unsigned NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                item_valid,
	output logic               item_ready,
	input  fpba_pkg::in_item_t item,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire [1:0]          cfg_data,
	output logic               push_valid,
	input  wire                push_ready,
	output fpba_pkg::op_t      push
);

	fpba_pkg::policy_t policy_q;
	logic              op_vld_s1;
	fpba_pkg::op_t     op_s1;
	fpba_pkg::op_kind_t kind;

	assign cfg_ready  = 1'b1;
	assign item_ready = !op_vld_s1 || push_ready;
	assign push_valid = op_vld_s1;
	assign push       = op_s1;

	always_comb begin
		if (item.command == fpba_pkg::CMD_ALLOC) begin
			kind = fpba_pkg::OP_ALLOC;
		end else if (32'(item.block_index) < NUM_BLOCKS) begin
			kind = fpba_pkg::OP_LOAD;
		end else begin
			kind = fpba_pkg::OP_LOAD_DROP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= fpba_pkg::POL_FIRST;
			op_vld_s1 <= 1'b0;
			op_s1     <= '0;
		end else begin
			if (cfg_valid) begin
				policy_q <= fpba_pkg::policy_t'(cfg_data);
			end
			if (item_valid && item_ready) begin
				op_vld_s1     <= 1'b1;
				op_s1.kind    <= kind;
				op_s1.index   <= item.block_index;
				op_s1.amount  <= item.amount;
				op_s1.policy  <= policy_q;
			end else if (push_ready) begin
				op_vld_s1 <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[src/fpba_queue.sv]
// Short queue of classified requests between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module fpba_queue (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           push_valid,
	output logic          push_ready,
	input  fpba_pkg::op_t push,
	output logic          pop_valid,
	input  wire           pop_ready,
	output fpba_pkg::op_t pop
);

	localparam int unsigned PW = $clog2(fpba_pkg::QUEUE_DEPTH);

	fpba_pkg::op_t entries_q [fpba_pkg::QUEUE_DEPTH];
	logic [PW:0]   wr_ptr_q;
	logic [PW:0]   rd_ptr_q;
	logic          full;
	logic          empty;

	assign empty      = wr_ptr_q == rd_ptr_q;
	assign full       = (wr_ptr_q[PW] != rd_ptr_q[PW]) &&
	                    (wr_ptr_q[PW-1:0] == rd_ptr_q[PW-1:0]);
	assign push_ready = !full;
	assign pop_valid  = !empty;
	assign pop        = entries_q[rd_ptr_q[PW-1:0]];

	always_ff @(posedge clk) begin
		if (push_valid && !full) begin
			entries_q[wr_ptr_q[PW-1:0]] <= push;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push_valid && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_ready && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[src/fpba_back.sv]
// Back end: capacity memory, placement scan and result register.
`timescale 1ns / 1ps
`default_nettype none
module fpba_back #(
	parameter int unsigned NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 op_valid,
	output logic                op_ready,
	input  fpba_pkg::op_t       op,
	output logic                result_valid,
	input  wire                 result_ready,
	output fpba_pkg::out_item_t result
);

	localparam int unsigned IW = $clog2(NUM_BLOCKS);
	localparam int unsigned CW = $clog2(NUM_BLOCKS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t              state_q;
	logic [15:0]         amount_q;
	fpba_pkg::policy_t   policy_q;
	logic [IW-1:0]       addr_q;
	logic [CW-1:0]       cnt_q;
	logic                cmp_vld_s1;
	logic [IW-1:0]       cmp_idx_s1;
	logic                found_q;
	logic [IW-1:0]       pick_idx_q;
	logic [15:0]         pick_val_q;
	logic [IW-1:0]       next_ptr_q;
	logic                result_valid_q;
	fpba_pkg::out_item_t result_q;

	logic [15:0]         mem_q [NUM_BLOCKS];
	logic [15:0]         rd_data_s1;

	logic                slot_free;
	logic                issue;
	logic                scan_end;
	logic                fit;
	logic                take;
	logic                load_wr;
	logic                fin_wr;
	logic                wr_en;
	logic [IW-1:0]       wr_addr;
	logic [15:0]         wr_data;
	logic [IW-1:0]       addr_nxt;
	logic [15:0]         left;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign slot_free = !result_valid_q || result_ready;
	assign issue     = (state_q == S_SCAN) && (cnt_q != CW'(NUM_BLOCKS));
	assign scan_end  = (state_q == S_SCAN) && !issue && !cmp_vld_s1;
	assign op_ready  = (state_q == S_IDLE) && ((op.kind == fpba_pkg::OP_ALLOC) || slot_free);
	assign load_wr   = (state_q == S_IDLE) && op_valid && (op.kind == fpba_pkg::OP_LOAD) &&
	                   slot_free;
	assign fin_wr    = (state_q == S_FINISH) && slot_free && found_q;
	assign left      = pick_val_q - amount_q;
	assign wr_en     = load_wr || fin_wr;
	assign wr_addr   = load_wr ? IW'(op.index) : pick_idx_q;
	assign wr_data   = load_wr ? op.amount : left;
	assign addr_nxt  = (addr_q == IW'(NUM_BLOCKS - 1)) ? '0 : addr_q + 1'b1;
	assign fit       = cmp_vld_s1 && (rd_data_s1 >= amount_q);

	always_comb begin
		unique case (policy_q)
			fpba_pkg::POL_FIRST,
			fpba_pkg::POL_NEXT:  take = fit && !found_q;
			fpba_pkg::POL_BEST:  take = fit && (!found_q || (rd_data_s1 < pick_val_q));
			fpba_pkg::POL_WORST: take = fit && (!found_q || (rd_data_s1 > pick_val_q));
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_data_s1 <= mem_q[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			amount_q       <= '0;
			policy_q       <= fpba_pkg::POL_FIRST;
			addr_q         <= '0;
			cnt_q          <= '0;
			cmp_vld_s1     <= 1'b0;
			cmp_idx_s1     <= '0;
			found_q        <= 1'b0;
			pick_idx_q     <= '0;
			pick_val_q     <= '0;
			next_ptr_q     <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			cmp_vld_s1 <= issue;
			cmp_idx_s1 <= addr_q;
			unique case (state_q)
				S_IDLE: begin
					if (op_valid && op_ready) begin
						unique case (op.kind)
							fpba_pkg::OP_ALLOC: begin
								amount_q <= op.amount;
								policy_q <= op.policy;
								addr_q   <= (op.policy == fpba_pkg::POL_NEXT) ? next_ptr_q : '0;
								cnt_q    <= '0;
								found_q  <= 1'b0;
								state_q  <= S_SCAN;
							end
							fpba_pkg::OP_LOAD: begin
								next_ptr_q             <= '0;
								result_valid_q         <= 1'b1;
								result_q.status       <= fpba_pkg::ST_LOADED;
								result_q.block_number <= op.index;
								result_q.remaining    <= op.amount;
							end
							default: begin
								next_ptr_q             <= '0;
								result_valid_q         <= 1'b1;
								result_q.status       <= fpba_pkg::ST_LOADED;
								result_q.block_number <= op.index;
								result_q.remaining    <= '0;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (issue) begin
						addr_q <= addr_nxt;
						cnt_q  <= cnt_q + 1'b1;
					end
					if (take) begin
						found_q    <= 1'b1;
						pick_idx_q <= cmp_idx_s1;
						pick_val_q <= rd_data_s1;
					end
					if (scan_end) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (slot_free) begin
						result_valid_q <= 1'b1;
						if (found_q) begin
							result_q.status       <= fpba_pkg::ST_PLACED;
							result_q.block_number <= 4'(pick_idx_q);
							result_q.remaining    <= left;
							if (policy_q == fpba_pkg::POL_NEXT) begin
								next_ptr_q <= pick_idx_q;
							end
						end else begin
							result_q.status       <= fpba_pkg::ST_NOFIT;
							result_q.block_number <= '0;
							result_q.remaining    <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[src/fit_policy_block_allocator_unit.sv]
// Top level of the fit-policy block allocator.
// Requests enter on item_valid/item_ready as an in_item_t: a load sets the
// capacity of one block and clears the next-fit pointer, an allocate places a
// request size by the policy written on cfg_valid/cfg_data (cfg_ready is high).
// Every request gives one result on result_valid/result_ready: status, block
// number and capacity left in that block.
// A load goes through the front register, the request queue and the result
// register; loads sustain one per cycle while results are taken.
// An allocate reads every block once through the single read port of the
// capacity memory, one block per cycle; the back end takes no new request
// until the allocate's result is written to the result register.
// A two-entry request queue between front and back end lets the front keep
// accepting while a scan runs or a result waits.
// If the receiver stalls, the result register holds its result and the back
// end waits; the queue and front register fill and then item_ready drops.
// Reset clears the policy to first fit, the next-fit pointer to zero and all
// handshake state; block capacities are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module fit_policy_block_allocator_unit #(
	parameter int unsigned NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_ready,
	input  fpba_pkg::in_item_t  item,
	output logic                result_valid,
	input  wire                 result_ready,
	output fpba_pkg::out_item_t result,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire [1:0]           cfg_data
);

	logic          push_valid;
	logic          push_ready;
	fpba_pkg::op_t push;
	logic          pop_valid;
	logic          pop_ready;
	fpba_pkg::op_t pop;

	fpba_front #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push       (push)
	);

	fpba_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push       (push),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop        (pop)
	);

	fpba_back #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (pop_valid),
		.op_ready     (pop_ready),
		.op           (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire

[src/fpba_checker.sv]
// Port-level assertions for the fit-policy block allocator and their bind.
`timescale 1ns / 1ps
`default_nettype none
`include "fit_policy_block_allocator_unit_assert.svh"
module fpba_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 result_valid,
	input wire                 result_ready,
	input fpba_pkg::out_item_t result
);

	logic status_known;
	logic nofit_shown;
	logic nofit_clean;

	assign status_known = (result.status == fpba_pkg::ST_LOADED) ||
	                      (result.status == fpba_pkg::ST_PLACED) ||
	                      (result.status == fpba_pkg::ST_NOFIT);
	assign nofit_shown  = result_valid && (result.status == fpba_pkg::ST_NOFIT);
	assign nofit_clean  = (result.block_number == '0) && (result.remaining == '0);

	`FPBA_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid)
	`FPBA_ASSERT_NEXT(a_result_stable, clk, arst_n, result_valid && !result_ready, $stable(result))
	`FPBA_ASSERT_NOW(a_status_legal, clk, arst_n, result_valid, status_known)
	`FPBA_ASSERT_NOW(a_nofit_zero, clk, arst_n, nofit_shown, nofit_clean)

endmodule

bind fit_policy_block_allocator_unit fpba_checker u_fpba_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
`default_nettype wire
